@@ rtl/core/swpbi_pkg.sv @@
// Types, constants and the divider step for swept_point_box_impact.
// No dependencies.
package swpbi_pkg;

    localparam int QUO_BITS       = 21;
    localparam int BITS_PER_STAGE = 3;
    localparam int DIV_STAGES     = QUO_BITS / BITS_PER_STAGE;
    localparam int LANES          = 4;
    localparam logic [21:0] TIME_SAT = 22'd1048576;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] box_cx;
        logic signed [15:0] box_cy;
        logic [14:0]        half_x;
        logic [14:0]        half_y;
        logic [19:0]        time_limit;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [19:0] impact_time;
        logic        normal_axis;
        logic        normal_negative;
    } t_out;

    // one restoring-division lane
    typedef struct packed {
        logic [15:0] rem;
        logic [20:0] quo;
        logic [2:0]  low;   // dividend bits that enter in the first step
        logic        sat;
        logic        neg;
    } t_lane;

    typedef t_lane [LANES-1:0] t_lanes;

    // per-item control carried beside the divider
    typedef struct packed {
        logic [1:0]  vzero;
        logic [1:0]  vpos;
        logic [1:0]  outside;
        logic        in_box;
        logic        in_axis;
        logic        in_neg;
        logic [19:0] tlim;
    } t_side;

    // three quotient bits per call
    function automatic t_lane lane_step(t_lane l, logic [15:0] ud, logic first);
        t_lane      r;
        logic [16:0] s;
        logic        b;
        r = l;
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
            b = first ? r.low[2-j] : 1'b0;
            s = {r.rem, b};
            if (s >= {1'b0, ud}) begin
                s = s - {1'b0, ud};
                r.quo = {r.quo[19:0], 1'b1};
            end else begin
                r.quo = {r.quo[19:0], 1'b0};
            end
            r.rem = s[15:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/swept_point_box_impact.sv @@
// Swept point versus axis-aligned box, 2D slab test, fully pipelined.
// Depends on swpbi_pkg.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-----------------------
//  input   | i_valid | o_stall | i_item (swpbi_pkg::t_in)
//  result  | o_valid | i_stall | o_res  (swpbi_pkg::t_out)
//
// One transaction per cycle sustained while the result is not stalled.
// Pipeline depth is set by the four restoring dividers (21 quotient bits, 3 per stage).
// Reset clears the valid bits only; payload registers are not reset.
// A stalled result freezes the whole pipeline; o_stall rises only then.
module swept_point_box_impact (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  swpbi_pkg::t_in   i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output swpbi_pkg::t_out  o_res
);

    localparam int NV = swpbi_pkg::DIV_STAGES + 6;

    logic            adv;
    logic [NV-1:0]   r_vld;

    assign adv     = !(r_vld[NV-1] && i_stall);
    assign o_stall = r_vld[NV-1] && i_stall;
    assign o_valid = r_vld[NV-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    // stage 0: capture
    swpbi_pkg::t_in r_in;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in <= i_item;
        end
    end

    // stage A: offsets and velocity magnitudes
    logic signed [16:0] r_a_d   [2];
    logic [16:0]        r_a_ad  [2];
    logic [14:0]        r_a_h   [2];
    logic [15:0]        r_a_ud  [2];
    logic [1:0]         r_a_vneg, r_a_vzero;
    logic [19:0]        r_a_tlim;
    logic signed [16:0] n_a_d   [2];
    logic signed [15:0] vv      [2];

    always_comb begin
        n_a_d[0] = 17'(r_in.point_x) - 17'(r_in.box_cx);
        n_a_d[1] = 17'(r_in.point_y) - 17'(r_in.box_cy);
        vv[0]    = r_in.vel_x;
        vv[1]    = r_in.vel_y;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 2; a++) begin
                r_a_d[a]     <= n_a_d[a];
                r_a_ad[a]    <= n_a_d[a][16] ? 17'(-n_a_d[a]) : 17'(n_a_d[a]);
                r_a_ud[a]    <= vv[a][15] ? 16'(-17'(vv[a])) : 16'(vv[a]);
                r_a_vneg[a]  <= vv[a][15];
                r_a_vzero[a] <= (vv[a] == 16'sd0);
            end
            r_a_h[0]  <= r_in.half_x;
            r_a_h[1]  <= r_in.half_y;
            r_a_tlim  <= r_in.time_limit;
        end
    end

    // stage B: slab numerators, inside test
    logic [17:0]       r_b_anum [4];
    logic [3:0]        r_b_neg;
    logic [15:0]       r_b_ud   [2];
    swpbi_pkg::t_side  r_b_side;
    logic signed [18:0] num [4];
    logic signed [17:0] dep [2];
    swpbi_pkg::t_side  n_b_side;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            num[2*a]   = -19'(r_a_h[a]) - 19'(r_a_d[a]);
            num[2*a+1] =  19'(r_a_h[a]) - 19'(r_a_d[a]);
            dep[a]     = 18'(r_a_h[a]) - 18'(r_a_ad[a]);
            n_b_side.vzero[a]   = r_a_vzero[a];
            n_b_side.vpos[a]    = !r_a_vneg[a] && !r_a_vzero[a];
            n_b_side.outside[a] = r_a_ad[a] > 17'(r_a_h[a]);
        end
        n_b_side.in_box  = !n_b_side.outside[0] && !n_b_side.outside[1];
        n_b_side.in_axis = !(dep[0] < dep[1]);
        n_b_side.in_neg  = n_b_side.in_axis ? r_a_d[1][16] : r_a_d[0][16];
        n_b_side.tlim    = r_a_tlim;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 4; l++) begin
                r_b_anum[l] <= num[l][18] ? 18'(-num[l]) : 18'(num[l]);
                r_b_neg[l]  <= (num[l][18] != r_a_vneg[l/2]) && (num[l] != 19'sd0);
            end
            r_b_ud   <= r_a_ud;
            r_b_side <= n_b_side;
        end
    end

    // stage C: saturation check and divider seed, then divide stages
    swpbi_pkg::t_lanes r_dl   [swpbi_pkg::DIV_STAGES+1];
    logic [15:0]       r_dud  [swpbi_pkg::DIV_STAGES+1][2];
    swpbi_pkg::t_side  r_dside[swpbi_pkg::DIV_STAGES+1];
    logic [17:0]       top    [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            top[l] = r_b_anum[l] >> 3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 4; l++) begin
                r_dl[0][l].sat    <= top[l] >= 18'(r_b_ud[l/2]);
                r_dl[0][l].rem    <= (top[l] >= 18'(r_b_ud[l/2])) ? 16'd0 : top[l][15:0];
                r_dl[0][l].low    <= r_b_anum[l][2:0];
                r_dl[0][l].quo    <= '0;
                r_dl[0][l].neg    <= r_b_neg[l];
            end
            r_dud[0]   <= r_b_ud;
            r_dside[0] <= r_b_side;
        end
    end

    for (genvar k = 0; k < swpbi_pkg::DIV_STAGES; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int l = 0; l < 4; l++) begin
                    r_dl[k+1][l] <= swpbi_pkg::lane_step(r_dl[k][l], r_dud[k][l/2],
                                                         (k == 0));
                end
                r_dud[k+1]   <= r_dud[k];
                r_dside[k+1] <= r_dside[k];
            end
        end
    end

    // stage E: ceiling, saturation, slab bounds
    localparam int DL = swpbi_pkg::DIV_STAGES;
    logic signed [21:0] r_e_lo [2];
    logic signed [21:0] r_e_hi [2];
    swpbi_pkg::t_side   r_e_side;
    logic [21:0]        mag [4];
    logic signed [21:0] tt  [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            mag[l] = 22'(r_dl[DL][l].quo) +
                     22'(!r_dl[DL][l].neg && (r_dl[DL][l].rem != 16'd0));
            if (r_dl[DL][l].sat || mag[l] > swpbi_pkg::TIME_SAT) begin
                mag[l] = swpbi_pkg::TIME_SAT;
            end
            tt[l] = r_dl[DL][l].neg ? -$signed(mag[l]) : $signed(mag[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 2; a++) begin
                r_e_lo[a] <= (tt[2*a] < tt[2*a+1]) ? tt[2*a]   : tt[2*a+1];
                r_e_hi[a] <= (tt[2*a] < tt[2*a+1]) ? tt[2*a+1] : tt[2*a];
            end
            r_e_side <= r_dside[DL];
        end
    end

    // stage F: slab combine and result register
    swpbi_pkg::t_out    n_res;
    logic signed [21:0] t0, t1;
    logic               miss, found, ax, ng;

    always_comb begin
        t0    = '0;
        t1    = $signed(22'(r_e_side.tlim));
        miss  = 1'b0;
        found = 1'b0;
        ax    = 1'b0;
        ng    = 1'b0;
        for (int a = 0; a < 2; a++) begin
            if (r_e_side.vzero[a]) begin
                if (r_e_side.outside[a]) miss = 1'b1;
            end else begin
                if (r_e_lo[a] > t0) begin
                    t0    = r_e_lo[a];
                    found = 1'b1;
                    ax    = 1'(a);
                    ng    = r_e_side.vpos[a];
                end
                if (r_e_hi[a] < t1) t1 = r_e_hi[a];
                if (t0 > t1) miss = 1'b1;
            end
        end
        if (!found || t0 > $signed(22'(r_e_side.tlim))) miss = 1'b1;

        if (r_e_side.in_box) begin
            n_res.hit             = 1'b1;
            n_res.impact_time     = '0;
            n_res.normal_axis     = r_e_side.in_axis;
            n_res.normal_negative = r_e_side.in_neg;
        end else if (miss) begin
            n_res = '0;
        end else begin
            n_res.hit             = 1'b1;
            n_res.impact_time     = t0[19:0];
            n_res.normal_axis     = ax;
            n_res.normal_negative = ng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_res <= n_res;
        end
    end

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.hit) |-> (o_res.impact_time == '0 &&
            !o_res.normal_axis && !o_res.normal_negative))
        else $error("miss transaction carries nonzero fields");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_res)))
        else $error("stalled result changed");

endmodule
